// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and constants of the symmetric transposition table
// ----------------------------------------------------------------------------
package stt_pkg;

   // defaults for the top level parameters
   localparam int INDEX_BITS_DEF = 12;
   localparam int KEY_WORDS_DEF  = 2;

   // fixed geometry of the zobrist table
   localparam int ZOB_SIDE  = 32;
   localparam int ZOB_DEPTH = ZOB_SIDE * ZOB_SIDE;
   localparam int ZADDR_W   = $clog2(ZOB_DEPTH);
   localparam int ZOB_W     = 12;

   // field widths
   localparam int FUNC_W  = 3;
   localparam int CELL_W  = 7;
   localparam int DIM_W   = 5;
   localparam int AREA_W  = 2 * DIM_W;
   localparam int SCORE_W = 16;
   localparam int NODE_W  = 32;
   localparam int DEPTH_W = 6;
   localparam int BOUND_W = 2;
   localparam int MIRRORS = 4;
   localparam int MIR_W   = 2;

   // register file
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;
   localparam logic [DIM_W-1:0] ROWS_RST = 5'd8;
   localparam logic [DIM_W-1:0] COLS_RST = 5'd8;

   // bound tags stored with each entry
   localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd0;
   localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd1;
   localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

   typedef enum logic [FUNC_W-1:0] {
      FN_TOGGLE = 3'd0,
      FN_STORE  = 3'd1,
      FN_LOOKUP = 3'd2,
      FN_CLEAR  = 3'd3,
      FN_LOAD   = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_FLIP_ADDR,
      ST_FLIP_APPLY,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/stt_ram.sv =====
// ----------------------------------------------------------------------------
// stt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/symmetric_transposition_table.sv =====
// ----------------------------------------------------------------------------
// symmetric_transposition_table
// zobrist hashed transposition table probed over four board mirror images
// ----------------------------------------------------------------------------
// usage
//   req_* carries one transaction: toggle a cell, store a result, look up a
//   position, clear the four keys, or load one zobrist word. every request
//   produces exactly one rsp_* transaction (hit, score, window, stored).
//   csr_we writes board_rows (index 0) or board_cols (index 1) at once; only
//   write them while the block is idle.
// sequence, request accept to rsp_valid
//   clear, load, unused codes, toggle off the board: straight to ST_DONE
//   toggle: bit-serial divide by cols in ST_DIV, then ST_FLIP_ADDR and ST_FLIP_APPLY per mirror
//   store / lookup: ST_PROBE_RD then ST_PROBE_CHK per mirror probed (up to 4)
//   the single table port forces a read state, then a compare state, per probe
// throughput
//   one request in flight; req_ready rises again once the result sits in
//   the output register, so the next request overlaps a stalled response
// reset
//   keys, codes and config reset at once; the table is then swept to zero
//   one entry a cycle across all 2**INDEX_BITS slots, with req_ready held low
// stall
//   a low rsp_ready keeps the result; a second result waits in ST_DONE
// ----------------------------------------------------------------------------
module symmetric_transposition_table #(
   parameter int INDEX_BITS = stt_pkg::INDEX_BITS_DEF,
   parameter int KEY_WORDS  = stt_pkg::KEY_WORDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [stt_pkg::FUNC_W-1:0]          req_func,
   input  logic [stt_pkg::CELL_W-1:0]          req_cell_req,
   input  logic [stt_pkg::ZADDR_W-1:0]         req_zob_addr,
   input  logic [stt_pkg::ZOB_W-1:0]           req_zob_word,
   input  logic signed [stt_pkg::SCORE_W-1:0]  req_score,
   input  logic signed [stt_pkg::SCORE_W-1:0]  req_alpha,
   input  logic signed [stt_pkg::SCORE_W-1:0]  req_beta,
   input  logic [stt_pkg::NODE_W-1:0]          req_node_count,
   input  logic [stt_pkg::DEPTH_W-1:0]         req_search_depth,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic signed [stt_pkg::SCORE_W-1:0]  rsp_result_score,
   output logic signed [stt_pkg::SCORE_W-1:0]  rsp_new_alpha,
   output logic signed [stt_pkg::SCORE_W-1:0]  rsp_new_beta,
   output logic                                rsp_stored,
   // register write port
   input  logic                                csr_we,
   input  logic [stt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stt_pkg::DIM_W-1:0]           csr_wdata
);

   import stt_pkg::*;

   localparam int KEY_BITS = KEY_WORDS * 64;
   localparam int KB_W     = $clog2(KEY_BITS);
   localparam int SLOTS    = 1 << INDEX_BITS;
   // table entry layout: key, nodes, score, depth, bound
   localparam int BOUND_LO = 0;
   localparam int DEPTH_LO = BOUND_LO + BOUND_W;
   localparam int SCORE_LO = DEPTH_LO + DEPTH_W;
   localparam int NODE_LO  = SCORE_LO + SCORE_W;
   localparam int KEY_LO   = NODE_LO + NODE_W;
   localparam int ENTRY_W  = KEY_LO + KEY_BITS;

   // control state
   state_type                state_ff, state_in;
   logic                     clearing_ff, clearing_in;
   logic [INDEX_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic [DIM_W-1:0]         rows_ff, rows_in;
   logic [DIM_W-1:0]         cols_ff, cols_in;
   logic [KEY_BITS-1:0]      key_ff [MIRRORS];
   logic [KEY_BITS-1:0]      key_in [MIRRORS];
   logic [INDEX_BITS-1:0]    code_ff [MIRRORS];
   logic [INDEX_BITS-1:0]    code_in [MIRRORS];
   logic                     rsp_valid_ff, rsp_valid_in;

   // transaction working registers
   func_type                 func_ff, func_in;
   logic [CELL_W-1:0]        cell_ff, cell_in;     // dividend, then quotient
   logic [DIM_W-1:0]         rem_ff, rem_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [MIR_W-1:0]         mir_ff, mir_in;
   logic                     flip_ok_ff, flip_ok_in;
   logic [KB_W-1:0]          flip_bit_ff, flip_bit_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic signed [SCORE_W-1:0] alpha_ff, alpha_in;
   logic signed [SCORE_W-1:0] beta_ff, beta_in;
   logic [NODE_W-1:0]        nodes_ff, nodes_in;
   logic [DEPTH_W-1:0]       depth_ff, depth_in;
   logic                     hit_ff, hit_in;
   logic signed [SCORE_W-1:0] rscore_ff, rscore_in;
   logic                     stored_ff, stored_in;

   // output register
   logic                     rsp_hit_ff, rsp_hit_in;
   logic signed [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic signed [SCORE_W-1:0] rsp_alpha_ff, rsp_alpha_in;
   logic signed [SCORE_W-1:0] rsp_beta_ff, rsp_beta_in;
   logic                     rsp_stored_ff, rsp_stored_in;

   // memories
   logic                     zob_we;
   logic [ZADDR_W-1:0]       zob_raddr;
   logic [ZOB_W-1:0]         zob_rdata;
   logic [INDEX_BITS+ZOB_W-1:0] zob_wide;
   logic [INDEX_BITS-1:0]    zob_code;
   logic                     tbl_we;
   logic [INDEX_BITS-1:0]    tbl_waddr;
   logic [ENTRY_W-1:0]       tbl_wdata;
   logic [INDEX_BITS-1:0]    tbl_raddr;
   logic [ENTRY_W-1:0]       tbl_rdata;

   // shared arithmetic
   logic                     accept;
   logic [AREA_W-1:0]        area;
   logic [DIM_W:0]           trial;
   logic [DIM_W:0]           trial_diff;
   logic                     trial_ge;
   logic [DIM_W-1:0]         fl_row;
   logic [DIM_W-1:0]         fl_col;
   logic [AREA_W-1:0]        fl_cell;
   logic [DIM_W-1:0]         fl_row_p1;
   logic [DIM_W-1:0]         fl_col_p1;
   logic [KEY_BITS-1:0]      rd_key;
   logic [NODE_W-1:0]        rd_nodes;
   logic signed [SCORE_W-1:0] rd_score;
   logic [DEPTH_W-1:0]       rd_depth;
   logic [BOUND_W-1:0]       rd_bound;
   logic [BOUND_W-1:0]       new_bound;
   logic                     rsp_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !clearing_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // cell range check
   assign area = AREA_W'(rows_ff) * AREA_W'(cols_ff);

   // one restoring division step per cycle
   assign trial      = {rem_ff, cell_ff[CELL_W-1]};
   assign trial_ge   = trial >= {1'b0, cols_ff};
   assign trial_diff = trial - {1'b0, cols_ff};

   // mirrored cell: bit 0 of the mirror flips columns, bit 1 flips rows
   assign fl_row    = mir_ff[1] ? (rows_ff - cell_ff[DIM_W-1:0] - 5'd1) : cell_ff[DIM_W-1:0];
   assign fl_col    = mir_ff[0] ? (cols_ff - rem_ff - 5'd1) : rem_ff;
   assign fl_cell   = AREA_W'(fl_row) * AREA_W'(cols_ff) + AREA_W'(fl_col);
   assign fl_row_p1 = fl_row + 5'd1;
   assign fl_col_p1 = fl_col + 5'd1;
   // (row+1)*32 + (col+1) with both terms below 32
   assign zob_raddr = {fl_row_p1, fl_col_p1};

   assign zob_we   = accept && (func_type'(req_func) == FN_LOAD);
   assign zob_wide = {{INDEX_BITS{1'b0}}, zob_rdata};
   assign zob_code = zob_wide[INDEX_BITS-1:0];

   // table entry fields
   assign tbl_raddr = code_ff[mir_ff];
   assign rd_key    = tbl_rdata[KEY_LO +: KEY_BITS];
   assign rd_nodes  = tbl_rdata[NODE_LO +: NODE_W];
   assign rd_score  = tbl_rdata[SCORE_LO +: SCORE_W];
   assign rd_depth  = tbl_rdata[DEPTH_LO +: DEPTH_W];
   assign rd_bound  = tbl_rdata[BOUND_LO +: BOUND_W];

   always_comb begin
      if (score_ff >= beta_ff) begin
         new_bound = BOUND_LOWER;
      end else if (score_ff > alpha_ff) begin
         new_bound = BOUND_EXACT;
      end else begin
         new_bound = BOUND_UPPER;
      end
   end

   // a store writes the probed slot; the clearing pass owns the port first
   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = code_ff[mir_ff];
      tbl_wdata = {key_ff[mir_ff], nodes_ff, score_ff, depth_ff, new_bound};
      if (clearing_ff) begin
         tbl_we    = 1'b1;
         tbl_waddr = clr_addr_ff;
         tbl_wdata = '0;
      end else if (state_ff == ST_PROBE_CHK && func_ff == FN_STORE && rd_nodes <= nodes_ff) begin
         tbl_we = 1'b1;
      end
   end

   stt_ram #(
      .WIDTH (ZOB_W),
      .DEPTH (ZOB_DEPTH)
   ) u_zob_ram (
      .clock   (clock),
      .wr_en   (zob_we),
      .wr_addr (req_zob_addr),
      .wr_data (req_zob_word),
      .rd_addr (zob_raddr),
      .rd_data (zob_rdata)
   );

   stt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clearing_in   = clearing_ff;
      clr_addr_in   = clr_addr_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      key_in        = key_ff;
      code_in       = code_ff;
      func_in       = func_ff;
      cell_in       = cell_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      mir_in        = mir_ff;
      flip_ok_in    = flip_ok_ff;
      flip_bit_in   = flip_bit_ff;
      score_in      = score_ff;
      alpha_in      = alpha_ff;
      beta_in       = beta_ff;
      nodes_in      = nodes_ff;
      depth_in      = depth_ff;
      hit_in        = hit_ff;
      rscore_in     = rscore_ff;
      stored_in     = stored_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_alpha_in  = rsp_alpha_ff;
      rsp_beta_in   = rsp_beta_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      // clearing pass after reset
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (&clr_addr_ff) begin
            clearing_in = 1'b0;
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default:  ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in   = func_type'(req_func);
               cell_in   = req_cell_req;
               score_in  = req_score;
               alpha_in  = req_alpha;
               beta_in   = req_beta;
               nodes_in  = req_node_count;
               depth_in  = req_search_depth;
               hit_in    = 1'b0;
               rscore_in = '0;
               stored_in = 1'b0;
               rem_in    = '0;
               cnt_in    = '0;
               mir_in    = '0;
               state_in  = ST_DONE;
               case (func_type'(req_func)) inside
                  FN_TOGGLE: begin
                     if (AREA_W'(req_cell_req) < area) begin
                        state_in = ST_DIV;
                     end
                  end
                  FN_STORE, FN_LOOKUP: begin
                     state_in = ST_PROBE_RD;
                  end
                  FN_CLEAR: begin
                     for (int m = 0; m < MIRRORS; m++) begin
                        key_in[m]  = '0;
                        code_in[m] = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_DIV: begin
            rem_in  = trial_ge ? trial_diff[DIM_W-1:0] : trial[DIM_W-1:0];
            cell_in = {cell_ff[CELL_W-2:0], trial_ge};
            cnt_in  = cnt_ff + 3'd1;
            if (cnt_ff == 3'(CELL_W - 1)) begin
               state_in = ST_FLIP_ADDR;
            end
         end

         ST_FLIP_ADDR: begin
            // zobrist read is issued from zob_raddr this cycle
            flip_ok_in  = fl_cell < AREA_W'(KEY_BITS);
            flip_bit_in = fl_cell[KB_W-1:0];
            state_in    = ST_FLIP_APPLY;
         end

         ST_FLIP_APPLY: begin
            if (flip_ok_ff) begin
               code_in[mir_ff] = code_ff[mir_ff] ^ zob_code;
               key_in[mir_ff][flip_bit_ff] = ~key_ff[mir_ff][flip_bit_ff];
            end
            mir_in   = mir_ff + 1'b1;
            state_in = (&mir_ff) ? ST_DONE : ST_FLIP_ADDR;
         end

         ST_PROBE_RD: begin
            state_in = ST_PROBE_CHK;
         end

         ST_PROBE_CHK: begin
            mir_in   = mir_ff + 1'b1;
            state_in = (&mir_ff) ? ST_DONE : ST_PROBE_RD;
            if (func_ff == FN_STORE) begin
               if (rd_nodes <= nodes_ff) begin
                  stored_in = 1'b1;
                  state_in  = ST_DONE;
               end
            end else if (rd_key == key_ff[mir_ff] && rd_depth >= depth_ff) begin
               case (rd_bound)
                  BOUND_EXACT: begin
                     hit_in    = 1'b1;
                     rscore_in = rd_score;
                     state_in  = ST_DONE;
                  end
                  BOUND_LOWER: begin
                     if (rd_score >= beta_ff) begin
                        hit_in    = 1'b1;
                        rscore_in = rd_score;
                        state_in  = ST_DONE;
                     end else if (rd_score > alpha_ff) begin
                        alpha_in = rd_score;
                     end
                  end
                  BOUND_UPPER: begin
                     if (rd_score <= alpha_ff) begin
                        hit_in    = 1'b1;
                        rscore_in = rd_score;
                        state_in  = ST_DONE;
                     end else if (rd_score < beta_ff) begin
                        beta_in = rd_score;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_DONE: begin
            // hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = hit_ff;
               rsp_score_in  = rscore_ff;
               rsp_alpha_in  = alpha_ff;
               rsp_beta_in   = beta_ff;
               rsp_stored_in = stored_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         rows_ff      <= ROWS_RST;
         cols_ff      <= COLS_RST;
         rsp_valid_ff <= 1'b0;
         for (int m = 0; m < MIRRORS; m++) begin
            key_ff[m]  <= '0;
            code_ff[m] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff       <= key_in;
         code_ff      <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      cell_ff       <= cell_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      mir_ff        <= mir_in;
      flip_ok_ff    <= flip_ok_in;
      flip_bit_ff   <= flip_bit_in;
      score_ff      <= score_in;
      alpha_ff      <= alpha_in;
      beta_ff       <= beta_in;
      nodes_ff      <= nodes_in;
      depth_ff      <= depth_in;
      hit_ff        <= hit_in;
      rscore_ff     <= rscore_in;
      stored_ff     <= stored_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_alpha_ff  <= rsp_alpha_in;
      rsp_beta_ff   <= rsp_beta_in;
      rsp_stored_ff <= rsp_stored_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_result_score = rsp_score_ff;
   assign rsp_new_alpha    = rsp_alpha_ff;
   assign rsp_new_beta     = rsp_beta_ff;
   assign rsp_stored       = rsp_stored_ff;

`ifndef ASSERT_OFF
   // one transaction in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a store never reports a hit and a lookup never reports a write
   a_hit_stored_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_stored))
      else $error("response flags both hit and stored");

   // the divider leaves a remainder below the column count
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLIP_ADDR |-> rem_ff < cols_ff)
      else $error("division remainder out of range");

   // the table is swept before the first request is taken
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ready)
      else $error("request ready before table clear");
`endif

endmodule

// ===== dv/symmetric_transposition_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// symmetric_transposition_table_tb
// self-checking bench: a scoreboard mirrors the four mirrored keys and the
// table, predicts every response and compares it field by field while
// random handshake gaps and stalls run on both channels
// ----------------------------------------------------------------------------
module symmetric_transposition_table_tb;
   import stt_pkg::*;

   localparam int SLOT_CNT   = 1 << INDEX_BITS_DEF;
   localparam int CELL_LIMIT = KEY_WORDS_DEF * 64;
   localparam int IDLE_LIMIT = 20000;   // covers the table sweep after reset
   localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [CELL_W-1:0]         cell_idx;
      logic [ZADDR_W-1:0]        zaddr;
      logic [ZOB_W-1:0]          zword;
      logic signed [SCORE_W-1:0] score;
      logic signed [SCORE_W-1:0] alpha;
      logic signed [SCORE_W-1:0] beta;
      logic [NODE_W-1:0]         nodes;
      logic [DEPTH_W-1:0]        depth;
   } probe_req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [SCORE_W-1:0] score;
      logic signed [SCORE_W-1:0] alpha;
      logic signed [SCORE_W-1:0] beta;
      logic                      stored;
   } probe_rsp_type;

   // ------------------------------------------------------------------------
   // scoreboard: private copy of keys, zobrist words and table
   // ------------------------------------------------------------------------
   class probe_scoreboard;
      int unsigned rows = 32'(ROWS_RST);
      int unsigned cols = 32'(COLS_RST);
      logic [CELL_LIMIT-1:0] mirror_key [MIRRORS];
      logic [ZOB_W-1:0]      mirror_code [MIRRORS];
      logic [ZOB_W-1:0]      zob [ZOB_DEPTH];
      bit                    zob_loaded [ZOB_DEPTH];
      logic [CELL_LIMIT-1:0] slot_key [SLOT_CNT];
      logic [NODE_W-1:0]     slot_nodes [SLOT_CNT];
      logic signed [SCORE_W-1:0] slot_score [SLOT_CNT];
      logic [DEPTH_W-1:0]    slot_depth [SLOT_CNT];
      logic [BOUND_W-1:0]    slot_bound [SLOT_CNT];
      probe_rsp_type         pending_rsp [$];
      int                    errors = 0;

      function new();
         for (int m = 0; m < MIRRORS; m++) begin
            mirror_key[m] = '0;
            mirror_code[m] = '0;
         end
         for (int i = 0; i < ZOB_DEPTH; i++) zob_loaded[i] = 0;
         for (int i = 0; i < SLOT_CNT; i++) begin
            slot_key[i] = '0; slot_nodes[i] = '0; slot_score[i] = '0;
            slot_depth[i] = '0; slot_bound[i] = BOUND_LOWER;
         end
      endfunction

      // zobrist address a mirrored cell reads, ok = 0 when beyond the key
      function automatic void mirror_addr(int unsigned r, int unsigned c,
                                          output bit ok, output int unsigned a,
                                          output int unsigned bitpos);
         bitpos = r * cols + c;
         ok = bitpos < CELL_LIMIT;
         a = ((r + 1) * ZOB_SIDE + (c + 1)) % ZOB_DEPTH;
      endfunction

      // the four (row, col) images of a cell; valid = 0 when off the board
      function automatic bit images(int unsigned cell_num, output int unsigned ir[MIRRORS],
                                    output int unsigned ic[MIRRORS]);
         int unsigned r, c;
         if (cell_num >= rows * cols) return 0;
         r = cell_num / cols;
         c = cell_num % cols;
         ir[0] = r;            ic[0] = c;
         ir[1] = r;            ic[1] = cols - c - 1;
         ir[2] = rows - r - 1; ic[2] = c;
         ir[3] = rows - r - 1; ic[3] = cols - c - 1;
         return 1;
      endfunction

      // addresses a toggle would read that were never loaded
      function automatic void missing_words(int unsigned cell_num, ref int unsigned miss[$]);
         int unsigned ir[MIRRORS], ic[MIRRORS], a, bp;
         bit ok;
         miss.delete();
         if (!images(cell_num, ir, ic)) return;
         for (int m = 0; m < MIRRORS; m++) begin
            mirror_addr(ir[m], ic[m], ok, a, bp);
            if (ok && !zob_loaded[a] && !(a inside {miss})) miss.push_back(a);
         end
      endfunction

      function void note_request(probe_req_type t);
         probe_rsp_type e;
         int unsigned ir[MIRRORS], ic[MIRRORS], a, bp, idx;
         bit ok;
         logic signed [SCORE_W-1:0] v;
         e = '{hit: 1'b0, score: '0, alpha: t.alpha, beta: t.beta, stored: 1'b0};
         case (t.func)
            FN_TOGGLE: begin
               if (images(32'(t.cell_idx), ir, ic)) begin
                  for (int m = 0; m < MIRRORS; m++) begin
                     mirror_addr(ir[m], ic[m], ok, a, bp);
                     if (ok) begin
                        mirror_code[m] ^= zob[a];
                        mirror_key[m][bp] = ~mirror_key[m][bp];
                     end
                  end
               end
            end
            FN_STORE: begin
               for (int m = 0; m < MIRRORS; m++) begin
                  idx = 32'(mirror_code[m]);
                  if (slot_nodes[idx] <= t.nodes) begin
                     slot_key[idx] = mirror_key[m];
                     slot_nodes[idx] = t.nodes;
                     slot_depth[idx] = t.depth;
                     slot_score[idx] = t.score;
                     if (t.score >= t.beta)      slot_bound[idx] = BOUND_LOWER;
                     else if (t.score > t.alpha) slot_bound[idx] = BOUND_EXACT;
                     else                        slot_bound[idx] = BOUND_UPPER;
                     e.stored = 1'b1;
                     break;
                  end
               end
            end
            FN_LOOKUP: begin
               for (int m = 0; m < MIRRORS && !e.hit; m++) begin
                  idx = 32'(mirror_code[m]);
                  if (slot_key[idx] == mirror_key[m] && slot_depth[idx] >= t.depth) begin
                     v = slot_score[idx];
                     if (slot_bound[idx] == BOUND_EXACT) begin
                        e.hit = 1'b1; e.score = v;
                     end else if (slot_bound[idx] == BOUND_LOWER) begin
                        if (v >= e.beta) begin
                           e.hit = 1'b1; e.score = v;
                        end else if (v > e.alpha) e.alpha = v;
                     end else if (slot_bound[idx] == BOUND_UPPER) begin
                        if (v <= e.alpha) begin
                           e.hit = 1'b1; e.score = v;
                        end else if (v < e.beta) e.beta = v;
                     end
                  end
               end
            end
            FN_CLEAR: begin
               for (int m = 0; m < MIRRORS; m++) begin
                  mirror_key[m] = '0;
                  mirror_code[m] = '0;
               end
            end
            FN_LOAD: begin
               zob[t.zaddr] = t.zword;
               zob_loaded[t.zaddr] = 1;
            end
            default: ;
         endcase
         pending_rsp.push_back(e);
      endfunction

      function void check_response(probe_rsp_type got);
         probe_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("response transaction with nothing expected");
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (got.hit !== e.hit) begin
            $error("hit expected %0d actual %0d", e.hit, got.hit); errors++;
         end
         if (got.score !== e.score) begin
            $error("result_score expected %0d actual %0d", e.score, got.score); errors++;
         end
         if (got.alpha !== e.alpha) begin
            $error("new_alpha expected %0d actual %0d", e.alpha, got.alpha); errors++;
         end
         if (got.beta !== e.beta) begin
            $error("new_beta expected %0d actual %0d", e.beta, got.beta); errors++;
         end
         if (got.stored !== e.stored) begin
            $error("stored expected %0d actual %0d", e.stored, got.stored); errors++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals
   // ------------------------------------------------------------------------
   logic clock, reset;
   logic req_valid, req_ready;
   logic [FUNC_W-1:0] req_func;
   logic [CELL_W-1:0] req_cell_req;
   logic [ZADDR_W-1:0] req_zob_addr;
   logic [ZOB_W-1:0] req_zob_word;
   logic signed [SCORE_W-1:0] req_score, req_alpha, req_beta;
   logic [NODE_W-1:0] req_node_count;
   logic [DEPTH_W-1:0] req_search_depth;
   logic rsp_valid, rsp_ready, rsp_hit, rsp_stored;
   logic signed [SCORE_W-1:0] rsp_result_score, rsp_new_alpha, rsp_new_beta;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0] csr_wdata;

   probe_scoreboard sb = new();
   int idle_cycles = 0;
   int rsp_stall = 0;

   symmetric_transposition_table DUT (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // every input known from time zero
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      {req_func, req_cell_req, req_zob_addr, req_zob_word} = '0;
      {req_score, req_alpha, req_beta, req_node_count, req_search_depth} = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ROWS;
      csr_wdata = '0;
   end

   // ------------------------------------------------------------------------
   // response side: random stalls, checking, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response('{rsp_hit, rsp_result_score, rsp_new_alpha,
                                rsp_new_beta, rsp_stored});
         // watchdog: cycles with no transaction on either channel
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
         // mostly ready, short stalls, now and then a long one
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(0, 2);
         end
      end
   end

   // ------------------------------------------------------------------------
   // request driving
   // ------------------------------------------------------------------------
   function automatic int unsigned sender_gap();
      int unsigned p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // hold one transaction until accepted, then maybe idle
   task automatic push_request(probe_req_type t);
      int unsigned gap;
      req_valid <= 1'b1;
      req_func <= t.func;          req_cell_req <= t.cell_idx;
      req_zob_addr <= t.zaddr;     req_zob_word <= t.zword;
      req_score <= t.score;        req_alpha <= t.alpha;
      req_beta <= t.beta;          req_node_count <= t.nodes;
      req_search_depth <= t.depth;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(t);
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic probe_req_type noise_req();
      probe_req_type t;
      logic [127:0] rnd;
      rnd = {$urandom(), $urandom(), $urandom(), $urandom()};
      t = rnd[$bits(probe_req_type)-1:0];
      t.func = FN_CLEAR;
      return t;
   endfunction

   // toggles first load any zobrist word they would read unwritten
   task automatic send(probe_req_type t);
      int unsigned miss[$];
      probe_req_type ld;
      if (t.func == FN_TOGGLE) begin
         sb.missing_words(32'(t.cell_idx), miss);
         foreach (miss[i]) begin
            ld = noise_req();
            ld.func = FN_LOAD;
            ld.zaddr = ZADDR_W'(miss[i]);
            push_request(ld);
         end
      end
      push_request(t);
   endtask

   // searcher-like transaction with random content
   function automatic probe_req_type search_req();
      probe_req_type t = noise_req();
      int unsigned p = $urandom_range(0, 99);
      int lo;
      if (p < 36) begin
         t.func = FN_TOGGLE;
         if ($urandom_range(0, 9) != 0 && sb.rows * sb.cols > 0)
            t.cell_idx = CELL_W'($urandom_range(0,
                            (sb.rows * sb.cols > 128 ? 128 : sb.rows * sb.cols) - 1));
      end else if (p < 63) t.func = FN_STORE;
      else if (p < 92) t.func = FN_LOOKUP;
      else if (p < 94) t.func = FN_CLEAR;
      else if (p < 97) t.func = FN_LOAD;
      else t.func = FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
      if ($urandom_range(0, 4) != 0) begin
         // narrow scores so bounds, hits and narrowing all occur
         t.score = SCORE_W'($signed($urandom_range(0, 400)) - 200);
         lo = $signed($urandom_range(0, 400)) - 220;
         t.alpha = SCORE_W'(lo);
         t.beta = SCORE_W'(lo + int'($urandom_range(1, 120)));
      end
      case ($urandom_range(0, 19))
         0:       t.nodes = '0;
         1:       t.nodes = '1;
         2, 3:    t.nodes = $urandom();
         default: t.nodes = NODE_W'($urandom_range(0, 60));
      endcase
      if (t.func == FN_LOOKUP && $urandom_range(0, 2) != 0)
         t.depth = DEPTH_W'($urandom_range(0, 20));
      return t;
   endfunction

   // idle point: everything answered, block quiet, then registers written
   task automatic set_board(int unsigned rows, int unsigned cols);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we <= 1'b1; csr_index <= CSR_ROWS; csr_wdata <= DIM_W'(rows);
      @(posedge clock);
      csr_index <= CSR_COLS; csr_wdata <= DIM_W'(cols);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.rows = rows & 31;
      sb.cols = cols & 31;
   endtask

   task automatic run_random(int n);
      repeat (n) send(search_req());
   endtask

   task automatic run_directed();
      probe_req_type t;
      // operations and extremes on the reset board
      t = noise_req(); t.func = FN_LOAD; t.zaddr = '1; t.zword = '1; send(t);
      t = noise_req(); t.func = FN_LOAD; t.zaddr = '0; t.zword = '0; send(t);
      t = noise_req(); t.func = FN_LOOKUP; t.depth = '0; send(t);   // empty slot match
      t = noise_req(); t.func = FN_TOGGLE; t.cell_idx = 7'd0; send(t);
      t = noise_req(); t.func = FN_TOGGLE; t.cell_idx = 7'd63; send(t);
      t = noise_req(); t.func = FN_TOGGLE; t.cell_idx = 7'd64; send(t);   // off the board
      t = noise_req(); t.func = FN_TOGGLE; t.cell_idx = '1; send(t);
      t = noise_req(); t.func = FN_STORE; t.nodes = '1; t.depth = '1;
      t.score = 16'sh7fff; t.alpha = 16'sh8000; t.beta = 16'sh7fff; send(t);
      t = noise_req(); t.func = FN_LOOKUP; t.depth = '1;
      t.alpha = 16'sh8000; t.beta = 16'sh7fff; send(t);
      t = noise_req(); t.func = FN_STORE; t.nodes = '0; t.depth = 6'd0;
      t.score = 16'sh8000; t.alpha = 16'sd0; t.beta = 16'sd5; send(t);   // upper bound
      t = noise_req(); t.func = FN_STORE; t.nodes = 32'd3; t.score = 16'sd10;
      t.alpha = 16'sd20; t.beta = 16'sd30; send(t);
      t = noise_req(); t.func = FN_STORE; t.nodes = 32'd3; t.score = 16'sd40;
      t.alpha = 16'sd20; t.beta = 16'sd30; t.depth = 6'd9; send(t);     // lower bound
      t = noise_req(); t.func = FN_LOOKUP; t.alpha = 16'sd0; t.beta = 16'sd35;
      t.depth = 6'd1; send(t);
      t = noise_req(); t.func = FN_LOOKUP; t.alpha = 16'sd0; t.beta = 16'sd50;
      t.depth = 6'd1; send(t);
      for (int f = FN_UNUSED_FIRST; f <= FN_UNUSED_LAST; f++) begin
         t = noise_req(); t.func = FUNC_W'(f); send(t);
      end
      t = noise_req(); t.func = FN_CLEAR; send(t);
      t = noise_req(); t.func = FN_LOOKUP; t.depth = 6'd0; send(t);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(250);
      set_board(1, 1);   run_random(70);
      set_board(30, 30); run_random(170);
      set_board(1, 30);  run_random(90);
      set_board(30, 1);  run_random(90);
      set_board(0, 8);   run_random(30);
      set_board(31, 31); run_random(60);
      set_board(11, 11); run_random(200);
      set_board(5, 7);   run_random(120);
      set_board(8, 8);   run_random(200);
      // drain, then give the last transaction time to settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== symmetric_transposition_table.f =====
hdl/stt_pkg.sv
hdl/stt_ram.sv
hdl/symmetric_transposition_table.sv
dv/symmetric_transposition_table_tb.sv
